>>> src/dfpl_pkg.sv
package dfpl_pkg;

  localparam int NUM_LIGHTS = 8;
  localparam int SLOT_W     = $clog2(NUM_LIGHTS);

  // sqrt unit: four root bits per stage, divider: four quotient bits per stage
  localparam int SQ_STG     = 5;
  localparam int ROOT_W     = 4 * SQ_STG;
  localparam int DIV_STG    = 4;
  localparam int LIGHT_LAT  = SQ_STG + 4;
  localparam int FOG_PAD    = LIGHT_LAT - DIV_STG - 1;

  localparam int SQ_W       = 22;
  localparam int K_W        = 17;
  localparam int PROD_W     = 24;
  localparam int SUM_W      = PROD_W + $clog2(NUM_LIGHTS);
  localparam int S_W        = SUM_W - 16 + 1;

  localparam logic [15:0] FOG_DEPTH_RST = 16'd5120;

  typedef enum logic [1:0] {
    CFG_FOG_DEPTH   = 2'd0,
    CFG_SKY_THEME   = 2'd1,
    CFG_LIGHT_COUNT = 2'd2
  } cfg_idx_t;

  typedef enum logic [1:0] {
    SKY_BLACK = 2'd0,
    SKY_NIGHT = 2'd1,
    SKY_DAY   = 2'd2
  } sky_theme_t;

  typedef enum logic [1:0] {
    KIND_ORANGE = 2'd0,
    KIND_WHITE  = 2'd1
  } light_kind_t;

  typedef struct packed {
    logic signed [16:0] dx;
    logic signed [16:0] dy;
    logic               act;
    logic               white;
  } light_in_t;

  typedef struct packed {
    logic [K_W-1:0] k;
    logic           white;
  } light_out_t;

  function automatic logic [7:0] light_colour(input logic white, input logic [1:0] ch);
    logic [7:0] c;
    c = 8'd0;
    case (ch)
      2'd0:    c = white ? 8'd180 : 8'd220;
      2'd1:    c = white ? 8'd220 : 8'd120;
      2'd2:    c = white ? 8'd255 : 8'd30;
      default: c = 8'd0;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] fog_colour(input logic [1:0] theme, input logic [1:0] ch);
    logic [7:0] c;
    c = 8'd0;
    case (theme)
      SKY_NIGHT: c = (ch == 2'd2) ? 8'd15 : 8'd5;
      SKY_DAY:   c = (ch == 2'd0) ? 8'd10 : ((ch == 2'd1) ? 8'd60 : 8'd150);
      default:   c = 8'd0;
    endcase
    return c;
  endfunction

  // squared radius in q8.8 squared units
  function automatic logic [33:0] radius_sq(input logic white);
    return white ? 34'd2359296 : 34'd1638400;
  endfunction

  // radius with sixteen fraction bits
  function automatic logic [18:0] radius_q16(input logic white);
    return white ? 19'd393216 : 19'd327680;
  endfunction

  // ceil(2^24 / radius), exact for dividends below 2^19
  function automatic logic [21:0] radius_recip(input logic white);
    return white ? 22'd2796203 : 22'd3355444;
  endfunction

endpackage

>>> src/dfpl_light.sv
module dfpl_light (
  input  logic                   clk,
  input  logic                   en,
  input  dfpl_pkg::light_in_t    li,
  output dfpl_pkg::light_out_t   lo
);

  localparam int SQ_STG = dfpl_pkg::SQ_STG;
  localparam int ROOT_W = dfpl_pkg::ROOT_W;
  localparam int SQ_W   = dfpl_pkg::SQ_W;

  logic signed [33:0] dxx, dyy;
  logic [33:0]        sq;

  logic [SQ_W-1:0]    sq_r    [SQ_STG+1];
  logic [ROOT_W+3:0]  rem_r   [SQ_STG+1];
  logic [ROOT_W-1:0]  root_r  [SQ_STG+1];
  logic               act_r   [SQ_STG+1];
  logic               white_r [SQ_STG+1];
  logic [ROOT_W+3:0]  rem_nxt [SQ_STG];
  logic [ROOT_W-1:0]  root_nxt[SQ_STG];

  logic [40:0]        prod_r;
  logic               white7_r, white8_r, white9_r;
  logic [16:0]        lin_r;
  logic [16:0]        k_r;
  logic [18:0]        xd;
  logic [33:0]        lin_sq;

  assign dxx = li.dx * li.dx;
  assign dyy = li.dy * li.dy;
  assign sq  = $unsigned(dxx) + $unsigned(dyy);

  always_comb begin
    logic [2*ROOT_W-1:0] x;
    logic [ROOT_W+3:0]   rem, trial, sub;
    logic [ROOT_W-1:0]   root;
    int                  p;
    for (int st = 0; st < SQ_STG; st++) begin
      x    = {(2*ROOT_W-SQ_W-16)'(0), sq_r[st], 16'h0000};
      rem  = rem_r[st];
      root = root_r[st];
      for (int j = 0; j < 4; j++) begin
        p     = ROOT_W - 1 - 4 * st - j;
        trial = {rem[ROOT_W+1:0], x[2*p +: 2]};
        sub   = {2'b00, root, 2'b01};
        if (trial >= sub) begin
          rem  = trial - sub;
          root = {root[ROOT_W-2:0], 1'b1};
        end else begin
          rem  = trial;
          root = {root[ROOT_W-2:0], 1'b0};
        end
      end
      rem_nxt[st]  = rem;
      root_nxt[st] = root;
    end
  end

  assign xd     = act_r[SQ_STG] ?
                  dfpl_pkg::radius_q16(white_r[SQ_STG]) - root_r[SQ_STG][18:0] : 19'd0;
  assign lin_sq = 34'(lin_r) * 34'(lin_r);

  always_ff @(posedge clk) begin
    if (en) begin
      sq_r[0]    <= sq[SQ_W-1:0];
      rem_r[0]   <= '0;
      root_r[0]  <= '0;
      act_r[0]   <= li.act && (sq < dfpl_pkg::radius_sq(li.white));
      white_r[0] <= li.white;
      for (int st = 0; st < SQ_STG; st++) begin
        sq_r[st+1]    <= sq_r[st];
        rem_r[st+1]   <= rem_nxt[st];
        root_r[st+1]  <= root_nxt[st];
        act_r[st+1]   <= act_r[st];
        white_r[st+1] <= white_r[st];
      end
      prod_r   <= 41'(xd) * 41'(dfpl_pkg::radius_recip(white_r[SQ_STG]));
      white7_r <= white_r[SQ_STG];
      lin_r    <= prod_r[40:24];
      white8_r <= white7_r;
      k_r      <= lin_sq[32:16];
      white9_r <= white8_r;
    end
  end

  assign lo.k     = k_r;
  assign lo.white = white9_r;

endmodule

>>> src/dfpl_fog.sv
module dfpl_fog (
  input  logic        clk,
  input  logic        en,
  input  logic [15:0] fog_depth,
  input  logic [18:0] num,
  output logic [16:0] w
);

  localparam int DIV_STG = dfpl_pkg::DIV_STG;
  localparam int FOG_PAD = dfpl_pkg::FOG_PAD;

  logic [16:0] rem_r [DIV_STG];
  logic [15:0] q_r   [DIV_STG];
  logic        sat_r [DIV_STG];
  logic [16:0] rem_nxt [DIV_STG];
  logic [15:0] q_nxt   [DIV_STG];
  logic        sat_in;
  logic [33:0] qq;
  logic [16:0] w_r [FOG_PAD+1];

  // saturated when 5*d >= 4*depth, which also covers zero depth
  assign sat_in = 20'(num) >= 20'({fog_depth, 2'b00});

  always_comb begin
    logic [16:0] rem, r2;
    logic [15:0] q;
    logic        b;
    int          i;
    for (int st = 0; st < DIV_STG; st++) begin
      if (st == 0) begin
        rem = num[18:2];
        q   = '0;
      end else begin
        rem = rem_r[st-1];
        q   = q_r[st-1];
      end
      for (int j = 0; j < 4; j++) begin
        i  = 15 - 4 * st - j;
        b  = (st == 0 && j < 2) ? num[1-j] : 1'b0;
        r2 = {rem[15:0], b};
        if (r2 >= {1'b0, fog_depth}) begin
          rem  = r2 - {1'b0, fog_depth};
          q[i] = 1'b1;
        end else begin
          rem  = r2;
        end
      end
      rem_nxt[st] = rem;
      q_nxt[st]   = q;
    end
  end

  assign qq = 34'(q_r[DIV_STG-1]) * 34'(q_r[DIV_STG-1]);

  always_ff @(posedge clk) begin
    if (en) begin
      for (int st = 0; st < DIV_STG; st++) begin
        rem_r[st] <= rem_nxt[st];
        q_r[st]   <= q_nxt[st];
      end
      sat_r[0] <= sat_in;
      for (int st = 1; st < DIV_STG; st++) begin
        sat_r[st] <= sat_r[st-1];
      end
      w_r[0] <= sat_r[DIV_STG-1] ? 17'h10000 : qq[32:16];
      for (int s = 0; s < FOG_PAD; s++) begin
        w_r[s+1] <= w_r[s];
      end
    end
  end

  assign w = w_r[FOG_PAD];

endmodule

>>> src/distance_fog_point_light_shader_top.sv
// distance fog point light shader
// in channel: one item per accepted beat; tuser selects a light load (0) or a
// pixel shade (1). a load writes one slot of the light table and gives no
// result; a shade gives one rgb result on the out channel.
// cfg port: write fog depth, sky theme or light count while the block is idle.
// throughput: one item per cycle while the output is not stalled.
// every stage moves on one shared advance
// signal, so the pipeline holds while a result waits and in_tready is low
// then; nothing is lost or repeated across a stall.
// the fifteen stages are: operand capture, light distance squared, five
// square-root stages (four root bits each; the fog divider runs four stages
// beside them), reciprocal multiply, falloff, intensity, colour products,
// two summing stages, fog blend products and the clamped output register.
// reset clears the valid bits and loads the default configuration; the light
// table is not cleared and a slot must be loaded before it is counted in.
module distance_fog_point_light_shader_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // base_red, base_green, base_blue, distance, hit_x, hit_y, light_slot,
  // light_tile_x, light_tile_y, light_kind
  input  logic [95:0] in_tdata,
  // operation
  input  logic        in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // out_red, out_green, out_blue
  output logic [23:0] out_tdata,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  localparam int NL  = dfpl_pkg::NUM_LIGHTS;
  localparam int LAT = dfpl_pkg::LIGHT_LAT;
  localparam int TOT = LAT + 6;

  logic [15:0] fog_depth_r;
  logic [1:0]  sky_theme_r;
  logic [3:0]  light_count_r;
  logic [17:0] table_r [NL];

  logic        adv, acc;
  logic [TOT-1:0] v_r;

  logic [15:0] in_dist, in_hx, in_hy;
  logic [dfpl_pkg::SLOT_W-1:0] in_slot;
  logic [7:0]  in_tx, in_ty;
  logic [1:0]  in_kind;

  dfpl_pkg::light_in_t  li_nxt [NL];
  dfpl_pkg::light_in_t  li_r   [NL];
  dfpl_pkg::light_out_t lout   [NL];
  logic [18:0] fog_num_r;
  logic [16:0] w;

  logic [23:0] base_r [LAT+3];
  logic [dfpl_pkg::PROD_W-1:0] prod_r [NL][3];
  logic [dfpl_pkg::SUM_W-1:0]  lo_r [3];
  logic [dfpl_pkg::SUM_W-1:0]  hi_r [3];
  logic [dfpl_pkg::SUM_W-1:0]  acc_sum [3];
  logic [dfpl_pkg::S_W-1:0]    s_r [3];
  logic [28:0] ps_r [3];
  logic [24:0] pf_r [3];
  logic [16:0] w_a_r, w_b_r, w_c_r;
  logic [23:0] out_r;

  assign in_dist = in_tdata[39:24];
  assign in_hx   = in_tdata[55:40];
  assign in_hy   = in_tdata[71:56];
  assign in_slot = in_tdata[72 +: dfpl_pkg::SLOT_W];
  assign in_tx   = in_tdata[82:75];
  assign in_ty   = in_tdata[90:83];
  assign in_kind = in_tdata[92:91];

  assign adv       = !v_r[TOT-1] || out_tready;
  assign in_tready = adv;
  assign acc       = in_tvalid && adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fog_depth_r   <= dfpl_pkg::FOG_DEPTH_RST;
      sky_theme_r   <= dfpl_pkg::SKY_DAY;
      light_count_r <= '0;
    end else if (cfg_we) begin
      unique case (dfpl_pkg::cfg_idx_t'(cfg_index))
        dfpl_pkg::CFG_FOG_DEPTH:   fog_depth_r   <= cfg_wdata;
        dfpl_pkg::CFG_SKY_THEME:   sky_theme_r   <= cfg_wdata[1:0];
        dfpl_pkg::CFG_LIGHT_COUNT: light_count_r <= cfg_wdata[3:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (acc && !in_tuser) begin
      table_r[in_slot] <= {in_kind, in_ty, in_tx};
    end
  end

  always_comb begin
    for (int i = 0; i < NL; i++) begin
      li_nxt[i].dx    = $signed({1'b0, in_hx}) - $signed({1'b0, table_r[i][7:0], 8'h80});
      li_nxt[i].dy    = $signed({1'b0, in_hy}) - $signed({1'b0, table_r[i][15:8], 8'h80});
      li_nxt[i].act   = (table_r[i][17:16] == dfpl_pkg::KIND_ORANGE ||
                         table_r[i][17:16] == dfpl_pkg::KIND_WHITE) &&
                        (light_count_r > 4'(i));
      li_nxt[i].white = table_r[i][16];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[TOT-2:0], acc && in_tuser};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      li_r      <= li_nxt;
      fog_num_r <= {in_dist, 2'b00} + 19'(in_dist);
      base_r[0] <= in_tdata[23:0];
      for (int s = 0; s < LAT + 2; s++) begin
        base_r[s+1] <= base_r[s];
      end
    end
  end

  for (genvar g = 0; g < NL; g++) begin : g_light
    dfpl_light u_light (
      .clk (clk),
      .en  (adv),
      .li  (li_r[g]),
      .lo  (lout[g])
    );
  end

  dfpl_fog u_fog (
    .clk       (clk),
    .en        (adv),
    .fog_depth (fog_depth_r),
    .num       (fog_num_r),
    .w         (w)
  );

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      acc_sum[c] = lo_r[c] + hi_r[c];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < NL; i++) begin
        for (int c = 0; c < 3; c++) begin
          prod_r[i][c] <= dfpl_pkg::PROD_W'(
            dfpl_pkg::light_colour(lout[i].white, 2'(c))) *
            dfpl_pkg::PROD_W'(lout[i].k);
        end
      end
      w_a_r <= w;
      for (int c = 0; c < 3; c++) begin
        logic [dfpl_pkg::SUM_W-1:0] a, b;
        a = '0;
        b = '0;
        for (int i = 0; i < NL; i += 2) begin
          a = a + dfpl_pkg::SUM_W'(prod_r[i][c]);
          if (i + 1 < NL) begin
            b = b + dfpl_pkg::SUM_W'(prod_r[i+1][c]);
          end
        end
        lo_r[c] <= a;
        hi_r[c] <= b;
      end
      w_b_r <= w_a_r;
      for (int c = 0; c < 3; c++) begin
        s_r[c] <= dfpl_pkg::S_W'(base_r[LAT+2][8*c +: 8]) +
                  dfpl_pkg::S_W'(acc_sum[c][dfpl_pkg::SUM_W-1:16]);
      end
      w_c_r <= w_b_r;
      for (int c = 0; c < 3; c++) begin
        ps_r[c] <= 29'(s_r[c]) * 29'(17'h10000 - w_c_r);
        pf_r[c] <= 25'(dfpl_pkg::fog_colour(sky_theme_r, 2'(c))) * 25'(w_c_r);
      end
      for (int c = 0; c < 3; c++) begin
        logic [29:0] t;
        t = 30'(ps_r[c]) + 30'(pf_r[c]);
        out_r[8*c +: 8] <= (t[29:16] > 14'd255) ? 8'd255 : t[23:16];
      end
    end
  end

  assign out_tvalid = v_r[TOT-1];
  assign out_tdata  = out_r;

  a_load_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && !in_tuser) |=> !v_r[0])
    else $error("load item entered the result pipeline");

  a_shade_enters: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tuser) |=> v_r[0])
    else $error("shade item lost at pipeline entry");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(v_r))
    else $error("valid bits moved during a stall");

endmodule
